// ===== design/iba_pkg.sv =====
// Package for the inode block allocator: operation and status codes, sequencer states,
// transaction payload types. No dependencies.
package iba_pkg;

    localparam logic [1:0] OP_CREATE    = 2'd0;
    localparam logic [1:0] OP_DELETE    = 2'd1;
    localparam logic [1:0] OP_TRANSLATE = 2'd2;
    localparam logic [1:0] OP_LIST      = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_NOENTRY  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_TOOBIG   = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] name_hi;
        logic [63:0] name_lo;
        logic [3:0]  block_count;
        logic [3:0]  block_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  block_address;
        logic [3:0]  entry_index;
        logic [3:0]  entry_size;
        logic [63:0] out_name_hi;
        logic [63:0] out_name_lo;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,    // count free blocks
        S_FINDFREE, // find free entry
        S_ALLOC,    // assign blocks
        S_FIND,     // name search
        S_FREE,     // release pointers, one per cycle
        S_PTRRD,    // pointer read for translate
        S_PTRWAIT,
        S_LIST,     // walk table for list
        S_LISTRD,
        S_OUT
    } state_t;

endpackage

// ===== design/iba_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
interface iba_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/inode_block_allocator.sv =====
// Inode block allocator top level.
// Depends on iba_pkg and iba_if.
//
// One transaction is processed at a time under a small sequencer; in_ch.ready is high only
// when idle with the output register empty. Create counts the free blocks, searches for a
// free entry, then scans the free map one block per cycle until the last requested block is
// taken, and then presents its result. Delete and translate search the table one entry per
// cycle; delete then releases the file's pointers, translate reads one. List walks the
// table with an extra read step per used entry, each result waiting in the output register
// until taken. The table and free-map walks use one shared counter; pointer release uses
// the pointer index instead.
module inode_block_allocator #(
    parameter int NUM_BLOCKS      = 128,
    parameter int NUM_ENTRIES     = 16,
    parameter int MAX_FILE_BLOCKS = 8
) (
    input  logic clk,
    input  logic rst_n,
    iba_if.sink   in_ch,
    iba_if.source out_ch
);
    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int EW = $clog2(NUM_ENTRIES);
    localparam int PW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    // in payload fields
    logic [1:0]  mode;
    logic [63:0] name_hi, name_lo;
    logic [3:0]  block_count, block_index;
    assign mode        = in_ch.payload.mode;
    assign name_hi     = in_ch.payload.name_hi;
    assign name_lo     = in_ch.payload.name_lo;
    assign block_count = in_ch.payload.block_count;
    assign block_index = in_ch.payload.block_index;

    iba_pkg::state_t state_reg, state_next;

    logic [NUM_BLOCKS-1:0]  used_blk_reg;
    logic [NUM_ENTRIES-1:0] used_ent_reg;
    logic [63:0] ent_hi_mem [NUM_ENTRIES];
    logic [63:0] ent_lo_mem [NUM_ENTRIES];
    logic [3:0]  ent_cnt_mem [NUM_ENTRIES];
    logic [BW-1:0] ptr_mem [NUM_ENTRIES*MAX_FILE_BLOCKS];

    logic [1:0]  op_reg;
    logic [63:0] nh_reg, nl_reg;
    logic [3:0]  cnt_reg, bidx_reg;
    logic [CW-1:0] ctr_reg;     // shared walk counter
    logic [CW-1:0] free_reg;
    logic [EW-1:0] ent_reg;
    logic [3:0]  i_reg;         // pointers done
    logic [EW:0] lastused_reg;
    logic [EW:0] lastused_c;
    logic        free_pend_reg;

    // output register
    logic        ov_reg;
    logic [2:0]  o_status_reg;
    logic [BW-1:0] o_addr_reg;
    logic [EW-1:0] o_idx_reg;
    logic [3:0]  o_size_reg;
    logic [63:0] o_hi_reg, o_lo_reg;
    logic        o_last_reg;

    logic [BW-1:0] ptr_rd_reg;
    logic [63:0] hi_rd_reg, lo_rd_reg;
    logic [3:0]  cnt_rd_reg;

    logic [BW-1:0] blk;
    logic [EW-1:0] ent_c;
    logic name_hit;
    logic in_acc, out_acc;
    logic [$clog2(NUM_ENTRIES*MAX_FILE_BLOCKS)-1:0] paddr;
    logic [PW-1:0] pofs;

    assign blk    = ctr_reg[BW-1:0];
    assign ent_c  = ctr_reg[EW-1:0];
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == iba_pkg::S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.payload.status        = o_status_reg;
    assign out_ch.payload.block_address = 7'(o_addr_reg);
    assign out_ch.payload.entry_index   = 4'(o_idx_reg);
    assign out_ch.payload.entry_size    = o_size_reg;
    assign out_ch.payload.out_name_hi   = o_hi_reg;
    assign out_ch.payload.out_name_lo   = o_lo_reg;
    assign out_ch.payload.last          = o_last_reg;

    assign name_hit = used_ent_reg[ent_c] && (ent_hi_mem[ent_c] == nh_reg)
                      && (ent_lo_mem[ent_c] == nl_reg);

    // highest used entry, with a flag that any entry is used
    always_comb
    begin
        lastused_c = '0;
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (used_ent_reg[k])
                lastused_c = {1'b1, EW'(k)};
    end

    always_comb
    begin
        pofs = '0;
        case (state_reg)
            iba_pkg::S_PTRRD: pofs = bidx_reg[PW-1:0];
            default:          pofs = i_reg[PW-1:0];
        endcase
        paddr = ($bits(paddr))'(ent_reg * MAX_FILE_BLOCKS + pofs);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iba_pkg::S_IDLE:
                if (in_acc)
                begin
                    case (mode)
                        iba_pkg::OP_CREATE:
                            state_next = (block_count > 4'(MAX_FILE_BLOCKS)) ?
                                iba_pkg::S_OUT : iba_pkg::S_COUNT;
                        iba_pkg::OP_LIST: state_next = iba_pkg::S_LIST;
                        default:          state_next = iba_pkg::S_FIND;
                    endcase
                end
            iba_pkg::S_COUNT:
                if (ctr_reg == CW'(NUM_BLOCKS - 1))
                    state_next = ((free_reg + CW'(!used_blk_reg[blk])) < CW'(cnt_reg)) ?
                        iba_pkg::S_OUT : iba_pkg::S_FINDFREE;
            iba_pkg::S_FINDFREE:
                if (!used_ent_reg[ent_c])
                    state_next = iba_pkg::S_ALLOC;
                else if (ctr_reg == CW'(NUM_ENTRIES - 1))
                    state_next = iba_pkg::S_OUT;
            iba_pkg::S_ALLOC:
                if (i_reg == cnt_reg || ctr_reg == CW'(NUM_BLOCKS))
                    state_next = iba_pkg::S_OUT;
            iba_pkg::S_FIND:
                if (name_hit)
                    state_next = (op_reg == iba_pkg::OP_DELETE) ? iba_pkg::S_FREE :
                        (bidx_reg >= ent_cnt_mem[ent_c] ||
                         bidx_reg >= 4'(MAX_FILE_BLOCKS)) ? iba_pkg::S_OUT :
                        iba_pkg::S_PTRRD;
                else if (ctr_reg == CW'(NUM_ENTRIES - 1))
                    state_next = iba_pkg::S_OUT;
            iba_pkg::S_FREE:
                if (i_reg >= ent_cnt_mem[ent_reg] || i_reg >= 4'(MAX_FILE_BLOCKS))
                    state_next = iba_pkg::S_OUT;
            iba_pkg::S_PTRRD:   state_next = iba_pkg::S_PTRWAIT;
            iba_pkg::S_PTRWAIT: state_next = iba_pkg::S_OUT;
            iba_pkg::S_LIST:
                if (ctr_reg == CW'(NUM_ENTRIES))
                    state_next = iba_pkg::S_OUT;
                else if (used_ent_reg[ent_c] && !(ov_reg && !out_acc))
                    state_next = iba_pkg::S_LISTRD;
            iba_pkg::S_LISTRD:  state_next = iba_pkg::S_LIST;
            iba_pkg::S_OUT:
                if (!ov_reg || out_acc)
                    state_next = iba_pkg::S_IDLE;
            default: state_next = iba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iba_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // memories and registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == iba_pkg::S_FINDFREE && state_next == iba_pkg::S_ALLOC)
        begin
            ent_hi_mem[ent_c]  <= nh_reg;
            ent_lo_mem[ent_c]  <= nl_reg;
            ent_cnt_mem[ent_c] <= cnt_reg;
        end
        if (state_reg == iba_pkg::S_ALLOC && i_reg != cnt_reg
            && ctr_reg != CW'(NUM_BLOCKS) && !used_blk_reg[blk])
            ptr_mem[paddr] <= blk;
        ptr_rd_reg <= ptr_mem[paddr];
        hi_rd_reg  <= ent_hi_mem[ent_c];
        lo_rd_reg  <= ent_lo_mem[ent_c];
        cnt_rd_reg <= ent_cnt_mem[ent_c];
    end

    // output valid: set by a list step or the final step, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (state_reg == iba_pkg::S_LISTRD)
            ov_reg <= 1'b1;
        else if (state_reg == iba_pkg::S_OUT && !ov_reg)
            ov_reg <= !(op_reg == iba_pkg::OP_LIST && lastused_reg[EW]);
        else if (out_acc)
            ov_reg <= 1'b0;
    end

    // Release pointers during delete; the pointer read is registered, so each release is
    // applied in the cycle after its index, one step behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            free_pend_reg <= 1'b0;
        else
            free_pend_reg <= (state_reg == iba_pkg::S_FREE) && (state_next == iba_pkg::S_FREE);
    end

    // datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_blk_reg <= '0;
            used_ent_reg <= '0;
            ctr_reg      <= '0;
            free_reg     <= '0;
            i_reg        <= '0;
            ent_reg      <= '0;
            lastused_reg <= '0;
            op_reg       <= '0;
            cnt_reg      <= '0;
            bidx_reg     <= '0;
            nh_reg       <= '0;
            nl_reg       <= '0;
            o_status_reg <= '0;
            o_addr_reg   <= '0;
            o_idx_reg    <= '0;
            o_size_reg   <= '0;
            o_hi_reg     <= '0;
            o_lo_reg     <= '0;
            o_last_reg   <= 1'b0;
        end
        else
        begin
            if (free_pend_reg)
                used_blk_reg[ptr_rd_reg] <= 1'b0;
            case (state_reg)
                iba_pkg::S_IDLE:
                    if (in_acc)
                    begin
                        op_reg   <= mode;
                        nh_reg   <= name_hi;
                        nl_reg   <= name_lo;
                        cnt_reg  <= block_count;
                        bidx_reg <= block_index;
                        ctr_reg  <= '0;
                        free_reg <= '0;
                        i_reg    <= '0;
                        lastused_reg <= lastused_c;
                        o_status_reg <= (mode == iba_pkg::OP_CREATE &&
                                         block_count > 4'(MAX_FILE_BLOCKS)) ?
                            iba_pkg::ST_TOOBIG : iba_pkg::ST_OK;
                        o_addr_reg <= '0;
                        o_idx_reg  <= '0;
                        o_size_reg <= '0;
                        o_hi_reg   <= '0;
                        o_lo_reg   <= '0;
                        o_last_reg <= 1'b1;
                    end
                iba_pkg::S_COUNT:
                begin
                    free_reg <= free_reg + CW'(!used_blk_reg[blk]);
                    if (state_next == iba_pkg::S_OUT)
                        o_status_reg <= iba_pkg::ST_NOSPACE;
                    ctr_reg <= (ctr_reg == CW'(NUM_BLOCKS - 1)) ? '0 : ctr_reg + 1'b1;
                end
                iba_pkg::S_FINDFREE:
                    if (state_next == iba_pkg::S_ALLOC)
                    begin
                        used_ent_reg[ent_c] <= 1'b1;
                        ent_reg   <= ent_c;
                        o_idx_reg <= ent_c;
                        ctr_reg   <= '0;
                    end
                    else if (state_next == iba_pkg::S_OUT)
                        o_status_reg <= iba_pkg::ST_NOENTRY;
                    else
                        ctr_reg <= ctr_reg + 1'b1;
                iba_pkg::S_ALLOC:
                    if (state_next != iba_pkg::S_OUT)
                    begin
                        if (!used_blk_reg[blk])
                        begin
                            used_blk_reg[blk] <= 1'b1;
                            i_reg <= i_reg + 1'b1;
                        end
                        ctr_reg <= ctr_reg + 1'b1;
                    end
                iba_pkg::S_FIND:
                    if (name_hit)
                    begin
                        ent_reg <= ent_c;
                        if (state_next == iba_pkg::S_OUT)
                        begin
                            o_status_reg <= iba_pkg::ST_RANGE;
                            o_idx_reg    <= '0;
                        end
                        else
                            o_idx_reg <= ent_c;
                    end
                    else if (state_next == iba_pkg::S_OUT)
                        o_status_reg <= iba_pkg::ST_NOTFOUND;
                    else
                        ctr_reg <= ctr_reg + 1'b1;
                iba_pkg::S_FREE:
                    if (state_next == iba_pkg::S_OUT)
                        used_ent_reg[ent_reg] <= 1'b0;
                    else
                        i_reg <= i_reg + 1'b1;
                iba_pkg::S_PTRWAIT: o_addr_reg <= ptr_rd_reg;
                iba_pkg::S_LIST:
                    if (ctr_reg == CW'(NUM_ENTRIES))
                    begin
                        if (!lastused_reg[EW])
                            o_status_reg <= iba_pkg::ST_EMPTY;
                    end
                    else if (!used_ent_reg[ent_c])
                        ctr_reg <= ctr_reg + 1'b1;
                iba_pkg::S_LISTRD:
                begin
                    o_status_reg <= iba_pkg::ST_OK;
                    o_idx_reg    <= ent_c;
                    o_size_reg   <= cnt_rd_reg;
                    o_hi_reg     <= hi_rd_reg;
                    o_lo_reg     <= lo_rd_reg;
                    o_last_reg   <= (EW'(lastused_reg[EW-1:0]) == ent_c);
                    ctr_reg      <= ctr_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid &&
            $stable({o_status_reg, o_addr_reg, o_idx_reg, o_size_reg,
                     o_hi_reg, o_lo_reg, o_last_reg}))
        else $error("result changed while waiting");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while a result is pending");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> o_status_reg <= iba_pkg::ST_EMPTY)
        else $error("status code out of range");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && o_status_reg != iba_pkg::ST_OK |-> o_last_reg)
        else $error("error result without last");

endmodule

// ===== test/tb.sv =====
// Testbench for inode_block_allocator: directed and random create/delete/translate/list
// transactions, checked against a behavioral free-map and entry-table predictor.
// Depends on iba_pkg, iba_if and the inode_block_allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK    = 128;
    localparam int NENT    = 16;
    localparam int MAXBLK  = 8;
    localparam int STALL_LIMIT = 5000;

    class alloc_scoreboard;
        bit          blk_taken[NBLK];
        bit          ent_taken[NENT];
        logic [63:0] ent_hi[NENT];
        logic [63:0] ent_lo[NENT];
        logic [3:0]  ent_size[NENT];
        logic [6:0]  ent_ptr[NENT][MAXBLK];
        iba_pkg::rsp_t pending[$];
        int          errors;
        int          results;
        int          status_seen[8];

        function void clear();
            foreach (blk_taken[b]) blk_taken[b] = 0;
            foreach (ent_taken[e]) ent_taken[e] = 0;
        endfunction

        function int lookup(logic [63:0] hi, logic [63:0] lo);
            for (int e = 0; e < NENT; e++)
                if (ent_taken[e] && ent_hi[e] == hi && ent_lo[e] == lo)
                    return e;
            return -1;
        endfunction

        // Work out the results of one accepted transaction and update the table.
        function void note(iba_pkg::req_t r);
            iba_pkg::rsp_t x;
            int   e;
            int   free_cnt;
            int   n;
            int   last_e;
            x = '0;
            x.last = 1'b1;
            case (r.mode)
                iba_pkg::OP_CREATE:
                begin
                    free_cnt = 0;
                    foreach (blk_taken[b]) if (!blk_taken[b]) free_cnt++;
                    e = -1;
                    for (int i = NENT - 1; i >= 0; i--) if (!ent_taken[i]) e = i;
                    if (r.block_count > MAXBLK) x.status = iba_pkg::ST_TOOBIG;
                    else if (free_cnt < r.block_count) x.status = iba_pkg::ST_NOSPACE;
                    else if (e < 0) x.status = iba_pkg::ST_NOENTRY;
                    else
                    begin
                        n = 0;
                        ent_taken[e] = 1;
                        ent_hi[e] = r.name_hi;
                        ent_lo[e] = r.name_lo;
                        ent_size[e] = r.block_count;
                        for (int b = 0; b < NBLK && n < r.block_count; b++)
                            if (!blk_taken[b])
                            begin
                                blk_taken[b] = 1;
                                ent_ptr[e][n] = 7'(b);
                                n++;
                            end
                        x.status = iba_pkg::ST_OK;
                        x.entry_index = 4'(e);
                    end
                    pending.push_back(x);
                end
                iba_pkg::OP_DELETE:
                begin
                    e = lookup(r.name_hi, r.name_lo);
                    if (e < 0) x.status = iba_pkg::ST_NOTFOUND;
                    else
                    begin
                        for (int i = 0; i < ent_size[e]; i++) blk_taken[ent_ptr[e][i]] = 0;
                        ent_taken[e] = 0;
                        x.status = iba_pkg::ST_OK;
                        x.entry_index = 4'(e);
                    end
                    pending.push_back(x);
                end
                iba_pkg::OP_TRANSLATE:
                begin
                    e = lookup(r.name_hi, r.name_lo);
                    if (e < 0) x.status = iba_pkg::ST_NOTFOUND;
                    else if (r.block_index >= ent_size[e]) x.status = iba_pkg::ST_RANGE;
                    else
                    begin
                        x.status = iba_pkg::ST_OK;
                        x.entry_index = 4'(e);
                        x.block_address = ent_ptr[e][r.block_index[2:0]];
                    end
                    pending.push_back(x);
                end
                default:
                begin
                    last_e = -1;
                    foreach (ent_taken[i]) if (ent_taken[i]) last_e = i;
                    if (last_e < 0)
                    begin
                        x.status = iba_pkg::ST_EMPTY;
                        pending.push_back(x);
                    end
                    else
                        for (int i = 0; i < NENT; i++)
                            if (ent_taken[i])
                            begin
                                x = '0;
                                x.status = iba_pkg::ST_OK;
                                x.entry_index = 4'(i);
                                x.entry_size = ent_size[i];
                                x.out_name_hi = ent_hi[i];
                                x.out_name_lo = ent_lo[i];
                                x.last = (i == last_e);
                                pending.push_back(x);
                            end
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        endtask

        task check(iba_pkg::rsp_t got);
            iba_pkg::rsp_t w;
            results++;
            if (pending.size() == 0)
            begin
                report("unexpected transaction, status", 64'(got.status), 64'd0);
                return;
            end
            w = pending.pop_front();
            status_seen[got.status]++;
            if (got.status != w.status) report("status", 64'(got.status), 64'(w.status));
            if (got.block_address != w.block_address)
                report("block_address", 64'(got.block_address), 64'(w.block_address));
            if (got.entry_index != w.entry_index)
                report("entry_index", 64'(got.entry_index), 64'(w.entry_index));
            if (got.entry_size != w.entry_size)
                report("entry_size", 64'(got.entry_size), 64'(w.entry_size));
            if (got.out_name_hi != w.out_name_hi)
                report("out_name_hi", got.out_name_hi, w.out_name_hi);
            if (got.out_name_lo != w.out_name_lo)
                report("out_name_lo", got.out_name_lo, w.out_name_lo);
            if (got.last != w.last) report("last", 64'(got.last), 64'(w.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    bit   hold_req;
    int   sent;
    int   quiet_cycles;
    logic [63:0] pool_hi[8];
    logic [63:0] pool_lo[8];
    alloc_scoreboard sb = new();

    iba_if #(.payload_t(iba_pkg::req_t)) in_if();
    iba_if #(.payload_t(iba_pkg::rsp_t)) out_if();

    inode_block_allocator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if.sink),
        .out_ch (out_if.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready) sb.note(in_if.payload);
        if (rst_n && out_if.valid && out_if.ready) sb.check(out_if.payload);
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin
        out_if.ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_if.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
            begin
                out_if.ready <= calm || ($urandom_range(99) >= 38);
                @(posedge clk);
            end
        end
    end

    task issue(logic [1:0] mode, logic [63:0] hi, logic [63:0] lo,
               logic [3:0] cnt, logic [3:0] idx);
        iba_pkg::req_t r;
        r.mode = mode;
        r.name_hi = hi;
        r.name_lo = lo;
        r.block_count = cnt;
        r.block_index = idx;
        while (!calm && $urandom_range(99) < 38)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= r;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sent++;
    endtask

    initial
    begin
        int sel;
        int p;
        logic [63:0] hi;
        logic [63:0] lo;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        rst_n = 1'b0;
        quiet_cycles = 0;
        sb.clear();
        pool_hi[0] = '1;
        pool_lo[0] = '1;
        pool_hi[1] = '0;
        pool_lo[1] = '0;
        pool_hi[2] = '1;
        pool_lo[2] = '0;
        for (int i = 3; i < 8; i++)
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, size limits, translate bounds, then fill the disk
        issue(iba_pkg::OP_LIST, 0, 0, 0, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[3], pool_lo[3], 4'd15, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[0], pool_lo[0], 4'd8, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[1], pool_lo[1], 4'd0, 0);
        issue(iba_pkg::OP_TRANSLATE, pool_hi[0], pool_lo[0], 0, 4'd0);
        issue(iba_pkg::OP_TRANSLATE, pool_hi[0], pool_lo[0], 0, 4'd7);
        issue(iba_pkg::OP_TRANSLATE, pool_hi[0], pool_lo[0], 0, 4'd8);
        issue(iba_pkg::OP_TRANSLATE, pool_hi[1], pool_lo[1], 0, 4'd15);
        issue(iba_pkg::OP_DELETE, pool_hi[2], pool_lo[2], 0, 0);
        for (int i = 0; i < 14; i++)
            issue(iba_pkg::OP_CREATE, pool_hi[2 + i % 6], pool_lo[2 + i % 6], 4'd8, 0);
        issue(iba_pkg::OP_DELETE, pool_hi[1], pool_lo[1], 0, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[1], pool_lo[1], 4'd8, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[4], pool_lo[4], 4'd1, 0);   // disk full
        issue(iba_pkg::OP_LIST, 0, 0, 0, 0);
        issue(iba_pkg::OP_DELETE, pool_hi[0], pool_lo[0], 0, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[0], pool_lo[0], 4'd0, 0);
        issue(iba_pkg::OP_CREATE, pool_hi[5], pool_lo[5], 4'd1, 0);   // table full

        for (int k = 0; k < 430; k++)
        begin
            calm = (k >= 200 && k < 260);
            if (k == 100) hold_req = 1;
            if ($urandom_range(19) == 0)
            begin
                p = $urandom_range(3, 7);
                pool_hi[p] = {$urandom, $urandom};
                pool_lo[p] = {$urandom, $urandom};
            end
            p = $urandom_range(7);
            hi = pool_hi[p];
            lo = pool_lo[p];
            if ($urandom_range(9) == 0)
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            sel = $urandom_range(99);
            if (sel < 35)
                issue(iba_pkg::OP_CREATE, hi, lo,
                      4'(($urandom_range(9) == 0) ? $urandom_range(9, 15) :
                                                    $urandom_range(0, 8)),
                      4'($urandom_range(15)));
            else if (sel < 57)
                issue(iba_pkg::OP_DELETE, hi, lo, 4'($urandom_range(15)),
                      4'($urandom_range(15)));
            else if (sel < 87)
                issue(iba_pkg::OP_TRANSLATE, hi, lo, 4'($urandom_range(15)),
                      4'($urandom_range(15)));
            else
                issue(iba_pkg::OP_LIST, hi, lo, 4'($urandom_range(15)),
                      4'($urandom_range(15)));
        end
        calm = 0;
        in_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("run covered %0d transactions in, %0d results out", sent, sb.results);
        $display("status counts ok/nospace/noentry/notfound/range/toobig/empty: %0d %0d %0d %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        $display("    %0d %0d %0d", sb.status_seen[4], sb.status_seen[5], sb.status_seen[6]);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
